/* hdl/edm_pkg.sv */
// ----------------------------------------------------------------------------
// edm_pkg: shared types, constants and helpers of the edge mark block
// Frame geometry, look-ahead distance, pixel chain tap positions and the
// packed transfer types of the pixel and result channels.
// ----------------------------------------------------------------------------
package edm_pkg;

    localparam int IMAGE_WIDTH  = 128;
    localparam int IMAGE_HEIGHT = 64;
    localparam int LOOK_AHEAD   = 4;

    localparam int PIX_W     = 8;
    localparam int OUT_COL_W = 7;
    localparam int OUT_ROW_W = 6;

    localparam int COL_W = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
    localparam int ROW_W = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;

    localparam int DRAIN_ROWS = (LOOK_AHEAD < IMAGE_HEIGHT) ? LOOK_AHEAD : IMAGE_HEIGHT;

    // one cell per pixel of the look-ahead window
    localparam int CHAIN_LEN = LOOK_AHEAD * IMAGE_WIDTH;

    // tap positions, cell 0 holds the newest pixel
    localparam int TAP_PIX_HERE  = CHAIN_LEN - 1;
    localparam int TAP_PIX_RIGHT = CHAIN_LEN - LOOK_AHEAD - 1;
    localparam int TAP_DRN_HERE  = DRAIN_ROWS * IMAGE_WIDTH - 1;
    localparam int TAP_DRN_RIGHT = (DRAIN_ROWS * IMAGE_WIDTH - LOOK_AHEAD - 1 > 0) ?
                                   (DRAIN_ROWS * IMAGE_WIDTH - LOOK_AHEAD - 1) : 0;

    localparam logic [PIX_W-1:0] THRESH_RESET = 8'd100;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [PIX_W-1:0] grey_value;
    } t_in_item;

    typedef struct packed {
        logic                 edge_mark;
        logic [OUT_COL_W-1:0] out_column;
        logic [OUT_ROW_W-1:0] out_row;
        logic                 frame_done;
    } t_out_item;

    typedef struct packed {
        logic [PIX_W-1:0] pix_here;
        logic [PIX_W-1:0] pix_right;
        logic [PIX_W-1:0] drn_here;
        logic [PIX_W-1:0] drn_right;
    } t_taps;

    function automatic logic exceeds(input logic [PIX_W-1:0] a,
                                     input logic [PIX_W-1:0] b,
                                     input logic [PIX_W-1:0] th);
        logic [PIX_W-1:0] diff;
        diff = (a > b) ? (a - b) : (b - a);
        return diff > th;
    endfunction

endpackage

/* hdl/lookahead_difference_edge_mark.sv */
// ----------------------------------------------------------------------------
// lookahead_difference_edge_mark: thresholded gradient edge marking
// Grey pixels arrive in raster order; each pixel is marked as an edge when
// it differs from the pixel LOOK_AHEAD columns right or LOOK_AHEAD rows
// below by more than the programmed threshold.
// ----------------------------------------------------------------------------
// usage
// - pixel channel (i_in_*): pixel items in raster order, or drain items once
//   a frame has ended; a transfer happens when valid is high and stall low
// - result channel (o_out_*): one mark per pixel with its column and row,
//   frame_done set on the last pixel of the frame
// - config channel (i_cfg_*): edge threshold, ready is always high; write it
//   only while no item is in flight
// - one item per cycle while the receiver does not stall, results in the
//   cycle after the transfer that causes them; the chain of pixel cells
//   shifts once per item
// - results of row r come out while row r+LOOK_AHEAD streams in; after the
//   frame, one drain item per remaining pixel of the last rows; pixel items
//   during the drain are dropped, drain items with nothing pending too
// - reset puts the position at the frame origin, ends any drain and sets
//   the threshold to 100; the pixel chain is not cleared
// - a stalled receiver holds the result register and stalls the pixel side
// ----------------------------------------------------------------------------
module lookahead_difference_edge_mark (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  edm_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output edm_pkg::t_out_item          o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [edm_pkg::PIX_W-1:0]   i_cfg_data
);
    import edm_pkg::*;

    logic [PIX_W-1:0] r_thresh;
    logic [COL_W-1:0] r_col,  n_col;
    logic [ROW_W-1:0] r_row,  n_row;
    logic [ROW_W-1:0] r_drow, n_drow;
    logic             r_draining, n_draining;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    t_taps            taps;
    logic             in_acc;
    logic             is_drain;
    logic             pix_go;
    logic             drn_go;
    logic             shift;
    logic             col_last;
    logic             row_last;
    logic             drow_last;
    logic             row_ready;
    logic             right_ok;
    logic             pix_mark;
    logic             drn_mark;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign is_drain    = (i_in_data.opcode == OP_DRAIN);
    assign pix_go      = in_acc && !is_drain && !r_draining;
    assign drn_go      = in_acc && is_drain && r_draining;
    assign shift       = pix_go || drn_go;

    assign col_last  = (r_col  == COL_W'(IMAGE_WIDTH - 1));
    assign row_last  = (r_row  == ROW_W'(IMAGE_HEIGHT - 1));
    assign drow_last = (r_drow == ROW_W'(IMAGE_HEIGHT - 1));
    assign row_ready = (32'(r_row) >= 32'(LOOK_AHEAD));
    assign right_ok  = ((32'(r_col) + 32'(LOOK_AHEAD)) < 32'(IMAGE_WIDTH));

    edm_chain u_chain (
        .i_clk   (i_clk),
        .i_shift (shift),
        .i_pix   (i_in_data.grey_value),
        .o_taps  (taps)
    );

    assign pix_mark = (right_ok && exceeds(taps.pix_here, taps.pix_right, r_thresh)) ||
                      exceeds(taps.pix_here, i_in_data.grey_value, r_thresh);
    assign drn_mark = right_ok && exceeds(taps.drn_here, taps.drn_right, r_thresh);

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_drow      = r_drow;
        n_draining  = r_draining;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // column counter runs for both the frame and the drain
        if (shift) begin
            n_col = col_last ? '0 : r_col + 1'b1;
        end

        if (pix_go) begin
            if (col_last) begin
                if (row_last) begin
                    n_row      = '0;
                    n_draining = 1'b1;
                    n_drow     = ROW_W'(IMAGE_HEIGHT - DRAIN_ROWS);
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            if (row_ready) begin
                n_out_valid          = 1'b1;
                n_out.edge_mark      = pix_mark;
                n_out.out_column     = OUT_COL_W'(r_col);
                n_out.out_row        = OUT_ROW_W'(32'(r_row) - 32'(LOOK_AHEAD));
                n_out.frame_done     = 1'b0;
            end
        end

        if (drn_go) begin
            if (col_last) begin
                n_drow = r_drow + 1'b1;
                if (drow_last) begin
                    n_draining = 1'b0;
                end
            end
            n_out_valid          = 1'b1;
            n_out.edge_mark      = drn_mark;
            n_out.out_column     = OUT_COL_W'(r_col);
            n_out.out_row        = OUT_ROW_W'(r_drow);
            n_out.frame_done     = col_last && drow_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= THRESH_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_drow      <= '0;
            r_draining  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_thresh <= i_cfg_data;
            end
            r_col       <= n_col;
            r_row       <= n_row;
            r_drow      <= n_drow;
            r_draining  <= n_draining;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_drain_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drn_go |=> r_out_valid)
        else $error("drain transfer without result");

    a_pixel_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_go && row_ready |=> r_out_valid)
        else $error("pixel transfer past look-ahead rows without result");

    a_drain_at_origin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_row == '0))
        else $error("frame row not at origin during drain");

    a_drain_ends_on_transfer : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_draining) && $past(i_rst_n) |-> $past(drn_go))
        else $error("drain ended without a drain transfer");

    a_done_on_last_pixel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_done |->
            (r_out.out_column == OUT_COL_W'(IMAGE_WIDTH - 1)) && !r_draining)
        else $error("frame_done on a pixel other than the last");
`endif

endmodule

/* hdl/edm_cell.sv */
// ----------------------------------------------------------------------------
// edm_cell: one pixel cell of the look-ahead chain
// Holds one grey value and takes its neighbor's value on every shift.
// ----------------------------------------------------------------------------
module edm_cell (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic [edm_pkg::PIX_W-1:0]  i_pix,
    output logic [edm_pkg::PIX_W-1:0]  o_pix
);
    import edm_pkg::*;

    logic [PIX_W-1:0] r_pix;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pix <= i_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

/* hdl/edm_chain.sv */
// ----------------------------------------------------------------------------
// edm_chain: row of pixel cells spanning the look-ahead window
// Pixels enter at cell 0 and move one cell per shift; fixed taps give the
// pixel under test and its right-hand partner for stream and drain items.
// ----------------------------------------------------------------------------
module edm_chain (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic [edm_pkg::PIX_W-1:0]  i_pix,
    output edm_pkg::t_taps             o_taps
);
    import edm_pkg::*;

    logic [PIX_W-1:0] cell_q [CHAIN_LEN];

    genvar g;
    generate
        for (g = 0; g < CHAIN_LEN; g++) begin : g_cell
            if (g == 0) begin : g_head
                edm_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (i_shift),
                    .i_pix   (i_pix),
                    .o_pix   (cell_q[g])
                );
            end else begin : g_body
                edm_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (i_shift),
                    .i_pix   (cell_q[g-1]),
                    .o_pix   (cell_q[g])
                );
            end
        end
    endgenerate

    assign o_taps.pix_here  = cell_q[TAP_PIX_HERE];
    assign o_taps.pix_right = cell_q[TAP_PIX_RIGHT];
    assign o_taps.drn_here  = cell_q[TAP_DRN_HERE];
    assign o_taps.drn_right = cell_q[TAP_DRN_RIGHT];

endmodule

/* tb/tb_lookahead_difference_edge_mark.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lookahead_difference_edge_mark: self-checking bench for the edge marker
// Streams the first rows of a frame through the block with random sender
// bursts and receiver stalls, plus stray drain items that must be dropped.
// The edge threshold is rewritten at idle points, including 0 and 255. A
// scoreboard class predicts every mark from its own line ring and compares
// each result transfer field by field.
// ----------------------------------------------------------------------------
module tb_lookahead_difference_edge_mark;
    import edm_pkg::*;

    localparam int RING_DEPTH  = LOOK_AHEAD * IMAGE_WIDTH;
    localparam int DRAIN_MARKS = DRAIN_ROWS * IMAGE_WIDTH;
    localparam int FRAME_ROWS  = 3 * LOOK_AHEAD;
    localparam int SEG_ROWS    = FRAME_ROWS / 4;
    localparam int HOLD_CYCLES = 1500;
    localparam int OPENING [8] = '{0, 255, 0, 255, 255, 255, 0, 0};

    typedef int unsigned t_seg_thresholds [4];
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    class edge_mark_board;
        bit [PIX_W-1:0] pixel_ring [RING_DEPTH];
        int             threshold = int'(THRESH_RESET);
        int             pix_col;
        int             pix_row;
        int             drain_left;
        t_out_item      marks_due [$];
        int             failures;

        function int slot(int r, int c);
            return (r % LOOK_AHEAD) * IMAGE_WIDTH + c;
        endfunction

        function bit differs(int a, int b);
            int d;
            d = (a > b) ? a - b : b - a;
            return d > threshold;
        endfunction

        // predict the mark caused by one accepted input transfer
        function void take_item(t_in_item it);
            t_out_item m;
            int idx, r, c, here;
            m = '0;
            if (it.opcode == OP_DRAIN) begin
                if (drain_left == 0)
                    return;
                idx = DRAIN_MARKS - drain_left;
                r = IMAGE_HEIGHT - DRAIN_ROWS + idx / IMAGE_WIDTH;
                c = idx % IMAGE_WIDTH;
                here = pixel_ring[slot(r, c)];
                if (c + LOOK_AHEAD < IMAGE_WIDTH)
                    m.edge_mark = differs(here, pixel_ring[slot(r, c + LOOK_AHEAD)]);
                m.out_column = OUT_COL_W'(c);
                m.out_row    = OUT_ROW_W'(r);
                m.frame_done = (drain_left == 1);
                marks_due.push_back(m);
                drain_left--;
                return;
            end
            // pixels are dropped while the drain runs
            if (drain_left != 0)
                return;
            here = pixel_ring[slot(pix_row, pix_col)];
            if (pix_row >= LOOK_AHEAD) begin
                if (pix_col + LOOK_AHEAD < IMAGE_WIDTH)
                    m.edge_mark = differs(here, pixel_ring[slot(pix_row, pix_col + LOOK_AHEAD)]);
                m.edge_mark  = m.edge_mark | differs(here, int'(it.grey_value));
                m.out_column = OUT_COL_W'(pix_col);
                m.out_row    = OUT_ROW_W'(pix_row - LOOK_AHEAD);
                marks_due.push_back(m);
            end
            pixel_ring[slot(pix_row, pix_col)] = it.grey_value;
            if (pix_col + 1 >= IMAGE_WIDTH) begin
                pix_col = 0;
                if (pix_row + 1 >= IMAGE_HEIGHT) begin
                    pix_row = 0;
                    drain_left = DRAIN_MARKS;
                end else begin
                    pix_row++;
                end
            end else begin
                pix_col++;
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_mark(t_out_item got);
            t_out_item want;
            if (marks_due.size() == 0) begin
                $error("result with nothing expected: column %0d row %0d",
                       got.out_column, got.out_row);
                failures++;
                return;
            end
            want = marks_due.pop_front();
            compare_field("edge_mark", 8'(want.edge_mark), 8'(got.edge_mark));
            compare_field("out_column", 8'(want.out_column), 8'(got.out_column));
            compare_field("out_row", 8'(want.out_row), 8'(got.out_row));
            compare_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [PIX_W-1:0]   i_cfg_data = '0;

    edge_mark_board     board;
    bit                 hold_request;
    int                 burst_left;
    int                 line_vals [IMAGE_WIDTH];

    lookahead_difference_edge_mark uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                board.check_mark(o_out_data);
            if (i_in_valid && !o_in_stall)
                board.take_item(i_in_data);
        end
    end

    function automatic t_in_item make_item(logic op, int grey);
        t_in_item it;
        it.opcode     = op;
        it.grey_value = PIX_W'(grey);
        return it;
    endfunction

    // one input transfer, preceded by a random gap when a burst runs out
    task automatic offer(t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            if (gap != 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        i_in_data  = it;
        i_in_valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall)
                break;
        end
        @(negedge i_clk);
    endtask

    task automatic wait_until_drained();
        i_in_valid = 1'b0;
        while (board.marks_due.size() != 0)
            @(negedge i_clk);
        // a pixel of an early row leaves nothing to wait for
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_threshold(int unsigned value);
        wait_until_drained();
        i_cfg_data  = PIX_W'(value);
        i_cfg_valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        board.threshold = int'(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_rows(t_seg_thresholds seg_th);
        int base, step, grey;
        for (int r = 0; r < FRAME_ROWS; r++) begin
            if (r % SEG_ROWS == 0)
                write_threshold(seg_th[r / SEG_ROWS]);
            if (r == FRAME_ROWS / 2)
                hold_request = 1'b1;
            for (int c = 0; c < IMAGE_WIDTH; c++) begin
                // stray drain mid-frame, nothing is pending so it is dropped
                if ($urandom_range(0, 19) == 0)
                    offer(make_item(OP_DRAIN, $urandom_range(0, 255)));
                if (c < 8 && r == 0) begin
                    grey = OPENING[c];
                end else if (c < 8 && r == LOOK_AHEAD) begin
                    grey = OPENING[7 - c];
                end else begin
                    case ($urandom_range(0, 7))
                        0: grey = 0;
                        1: grey = 255;
                        2, 3: grey = $urandom_range(0, 255);
                        default: begin
                            if (r >= LOOK_AHEAD && $urandom_range(0, 1) == 0)
                                base = board.pixel_ring[board.slot(r, c)];
                            else if (c >= LOOK_AHEAD)
                                base = line_vals[c - LOOK_AHEAD];
                            else
                                base = $urandom_range(0, 255);
                            // land on the threshold or one step either side of it
                            step = board.threshold - 1 + int'($urandom_range(0, 2));
                            if (step < 0)
                                step = 0;
                            grey = ($urandom_range(0, 1) == 0) ? base + step : base - step;
                            if (grey > 255 || grey < 0)
                                grey = (grey > 255) ? base - step : base + step;
                            if (grey > 255)
                                grey = 255;
                            if (grey < 0)
                                grey = 0;
                        end
                    endcase
                end
                line_vals[c] = grey;
                offer(make_item(OP_PIXEL, grey));
            end
        end
    endtask

    // receiver stall pattern, plus one long hold-off on request
    initial begin
        t_stall_mode mode;
        int mode_left;
        int phase;
        mode = STALL_NONE;
        mode_left = 0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (mode_left == 0) begin
                mode = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            phase++;
            case (mode)
                STALL_NONE:  i_out_stall = 1'b0;
                STALL_LIGHT: i_out_stall = ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall = ($urandom_range(0, 3) != 0);
                default:     i_out_stall = (phase % 5 < 2);
            endcase
        end
    end

    initial begin
        board = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // drains with nothing pending
        offer(make_item(OP_DRAIN, 8'hFF));
        offer(make_item(OP_DRAIN, 8'h00));
        run_rows('{100, 0, 255, $urandom_range(1, 254)});
        offer(make_item(OP_DRAIN, 8'h5A));
        i_in_valid = 1'b0;
        for (int n = 0; n < 5000 && board.marks_due.size() != 0; n++)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (board.marks_due.size() != 0) begin
            $error("%0d results never arrived", board.marks_due.size());
            board.failures++;
        end
        if (board.failures == 0)
            $display("tb_lookahead_difference_edge_mark OK");
        else
            $display("tb_lookahead_difference_edge_mark NOT OK");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("tb_lookahead_difference_edge_mark NOT OK");
        $finish;
    end

endmodule

/* lookahead_difference_edge_mark.f */
hdl/edm_pkg.sv
hdl/edm_cell.sv
hdl/edm_chain.sv
hdl/lookahead_difference_edge_mark.sv
tb/tb_lookahead_difference_edge_mark.sv
